@@ design/afpb_pkg.sv @@
// ----------------------------------------------------------------------------
// afpb_pkg
// Shared constants and types of the converter frame to packet builder.
// ----------------------------------------------------------------------------
package afpb_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int STATUS_LEN   = 3;
  localparam int BYTES_PER_CH = 3;
  localparam int PAYLOAD_LEN  = BYTES_PER_CH * NUM_CHANNELS;
  localparam int FRAME_LEN    = STATUS_LEN + PAYLOAD_LEN;
  localparam int PKT_LEN      = PAYLOAD_LEN + 3;

  localparam int POS_W     = $clog2(FRAME_LEN + 1);
  localparam int PAY_IDX_W = $clog2(PAYLOAD_LEN);
  localparam int CNT_W     = $clog2(PKT_LEN);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_FIRST  = 8'hBB;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  typedef logic [PAYLOAD_LEN-1:0][7:0] afpb_payload_t;

  typedef struct packed {
    afpb_payload_t payload;
    logic [23:0]   status;
    logic [23:0]   sample0;
    logic [23:0]   sample1;
    logic [7:0]    count;
  } afpb_desc_t;

  typedef struct packed {
    logic       valid;
    afpb_desc_t desc;
  } afpb_push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } afpb_qstat_t;

endpackage

@@ design/afpb_if.sv @@
// ----------------------------------------------------------------------------
// afpb_if
// Valid/ready channels for received bytes and for packet bytes.
// ----------------------------------------------------------------------------
interface afpb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface afpb_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         packet_byte;
  logic               packet_last;
  logic [23:0]        status_word;
  logic signed [23:0] sample_first;
  logic signed [23:0] sample_second;

  modport source (output valid, output packet_byte, output packet_last,
                  output status_word, output sample_first, output sample_second,
                  input ready);
  modport sink (input valid, input packet_byte, input packet_last,
                input status_word, input sample_first, input sample_second,
                output ready);
endinterface

@@ design/afpb_front.sv @@
// ----------------------------------------------------------------------------
// afpb_front
// Tracks the frame position, gathers status and samples, and hands a packet
// descriptor to the queue on the last byte of each frame.
// ----------------------------------------------------------------------------
module afpb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  afpb_in_if.sink              in_ch,
  input  afpb_pkg::afpb_qstat_t q_stat,
  output afpb_pkg::afpb_push_t  push
);

  logic [afpb_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [23:0]                status_r, status_nxt;
  logic [23:0]                s0_r, s0_nxt;
  logic [23:0]                s1_r, s1_nxt;
  logic [7:0]                 cnt_r, cnt_nxt;
  afpb_pkg::afpb_payload_t    pay_r, pay_nxt;

  logic                       take;
  logic                       open;
  logic [afpb_pkg::POS_W-1:0] idx;
  logic [afpb_pkg::POS_W-1:0] p;

  assign in_ch.ready = !q_stat.full;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    pos_nxt    = pos_r;
    status_nxt = status_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    cnt_nxt    = cnt_r;
    pay_nxt    = pay_r;
    push.valid = 1'b0;
    open = in_ch.frame_start ||
           (pos_r != '0 && pos_r < afpb_pkg::POS_W'(afpb_pkg::FRAME_LEN));
    idx  = in_ch.frame_start ? '0 : pos_r;
    p    = idx - afpb_pkg::POS_W'(afpb_pkg::STATUS_LEN);
    if (take) begin
      if (!open) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = idx + afpb_pkg::POS_W'(1);
        if (idx < afpb_pkg::POS_W'(afpb_pkg::STATUS_LEN)) begin
          status_nxt = {status_r[15:0], in_ch.rx_byte};
        end else begin
          pay_nxt[p[afpb_pkg::PAY_IDX_W-1:0]] = in_ch.rx_byte;
          if (p < afpb_pkg::POS_W'(afpb_pkg::BYTES_PER_CH)) begin
            s0_nxt = {s0_r[15:0], in_ch.rx_byte};
          end else if (p < afpb_pkg::POS_W'(2 * afpb_pkg::BYTES_PER_CH)) begin
            s1_nxt = {s1_r[15:0], in_ch.rx_byte};
          end
        end
        if (idx == afpb_pkg::POS_W'(afpb_pkg::FRAME_LEN - 1)) begin
          pos_nxt    = '0;
          push.valid = 1'b1;
          cnt_nxt    = cnt_r + 8'd1;
        end
      end
    end
    push.desc.payload = pay_nxt;
    push.desc.status  = status_nxt;
    push.desc.sample0 = s0_nxt;
    push.desc.sample1 = s1_nxt;
    push.desc.count   = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      status_r <= '0;
      s0_r     <= '0;
      s1_r     <= '0;
      cnt_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
      s0_r     <= s0_nxt;
      s1_r     <= s1_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

endmodule

@@ design/afpb_queue.sv @@
// ----------------------------------------------------------------------------
// afpb_queue
// Short queue of packet descriptors between the frame front and the packet
// serializer.
// ----------------------------------------------------------------------------
module afpb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  afpb_pkg::afpb_push_t  push,
  input  logic                  pop,
  output afpb_pkg::afpb_desc_t  head,
  output afpb_pkg::afpb_qstat_t q_stat
);

  afpb_pkg::afpb_desc_t        mem_r [afpb_pkg::QDEPTH];
  logic [afpb_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [afpb_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [afpb_pkg::QLVL_W-1:0] lvl_r, lvl_nxt;

  assign head          = mem_r[rp_r];
  assign q_stat.full   = (lvl_r == afpb_pkg::QLVL_W'(afpb_pkg::QDEPTH));
  assign q_stat.empty  = (lvl_r == '0);
  assign q_stat.level  = lvl_r;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    lvl_nxt = lvl_r;
    if (push.valid) begin
      wp_nxt = (wp_r == afpb_pkg::QPTR_W'(afpb_pkg::QDEPTH - 1)) ? '0
             : wp_r + afpb_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == afpb_pkg::QPTR_W'(afpb_pkg::QDEPTH - 1)) ? '0
             : rp_r + afpb_pkg::QPTR_W'(1);
    end
    if (push.valid && !pop) begin
      lvl_nxt = lvl_r + afpb_pkg::QLVL_W'(1);
    end else if (pop && !push.valid) begin
      lvl_nxt = lvl_r - afpb_pkg::QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wp_r] <= push.desc;
    end
  end

endmodule

@@ design/afpb_back.sv @@
// ----------------------------------------------------------------------------
// afpb_back
// Packet serializer: walks the head descriptor one byte per transfer into a
// registered output stage.
// ----------------------------------------------------------------------------
module afpb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  afpb_pkg::afpb_desc_t  head,
  input  afpb_pkg::afpb_qstat_t q_stat,
  output logic                  pop,
  afpb_out_if.source            out_ch
);

  logic [afpb_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           valid_r, valid_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           last_r, last_nxt;
  logic [23:0]                    status_r, s0_r, s1_r;
  logic                           load;
  logic                           fill;
  logic [afpb_pkg::CNT_W-1:0]     pidx;

  assign load = !valid_r || out_ch.ready;
  assign fill = load && !q_stat.empty;
  assign pidx = cnt_r - afpb_pkg::CNT_W'(2);

  always_comb begin
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    valid_nxt = load ? !q_stat.empty : valid_r;
    last_nxt  = (cnt_r == afpb_pkg::CNT_W'(afpb_pkg::PKT_LEN - 1));
    priority if (cnt_r == '0) begin
      byte_nxt = afpb_pkg::HDR_FIRST;
    end else if (cnt_r == afpb_pkg::CNT_W'(1)) begin
      byte_nxt = afpb_pkg::HDR_SECOND;
    end else if (last_nxt) begin
      byte_nxt = head.count;
    end else begin
      byte_nxt = head.payload[pidx[afpb_pkg::PAY_IDX_W-1:0]];
    end
    if (fill) begin
      if (last_nxt) begin
        cnt_nxt = '0;
        pop     = 1'b1;
      end else begin
        cnt_nxt = cnt_r + afpb_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      byte_r   <= byte_nxt;
      last_r   <= last_nxt;
      status_r <= head.status;
      s0_r     <= head.sample0;
      s1_r     <= (afpb_pkg::NUM_CHANNELS > 1) ? head.sample1 : 24'd0;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.packet_byte   = byte_r;
  assign out_ch.packet_last   = last_r;
  assign out_ch.status_word   = status_r;
  assign out_ch.sample_first  = s0_r;
  assign out_ch.sample_second = s1_r;

endmodule

@@ design/adc_frame_to_packet_builder_unit.sv @@
// ----------------------------------------------------------------------------
// adc_frame_to_packet_builder_unit
// Deserializes converter frames and emits one nine-byte packet per frame.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while the queue is not full; one
// packet byte per cycle out while the sink is ready. The last frame byte
// writes a queue descriptor that the serializer moves byte by byte out.
// The descriptor queue holds two packets; the input stalls while it is full,
// which happens when a frame ends before the packet ahead has fully left.
// Reset clears the frame position, status, samples, counter, queue and
// output valid; the raw payload store is not cleared.
module adc_frame_to_packet_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  afpb_in_if.sink     in_ch,
  afpb_out_if.source  out_ch
);

  afpb_pkg::afpb_push_t  push;
  afpb_pkg::afpb_desc_t  head;
  afpb_pkg::afpb_qstat_t q_stat;
  logic                  pop;

  afpb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push)
  );

  afpb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  afpb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= afpb_pkg::QLVL_W'(afpb_pkg::QDEPTH))
    else $error("Descriptor queue level exceeds its depth.");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && q_stat.full))
    else $error("Descriptor written while the queue is full.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("Descriptor released while the queue is empty.");

  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.packet_last))
    else $error("Packet released without its final byte in the output stage.");

endmodule
